// ===== hw/rtl/linear_probe_hash_set_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the hash set checkers.
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPHS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lphs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_pkg
// Types, codes and constants shared by the linear probing hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

  // Default build sizes.
  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_KEY_WIDTH = 32;

  // Fixed field widths of the request and response.
  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 32;
  localparam int HASH_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int PCT_W    = 7;

  // Load percent scale and limit register reset value.
  localparam int PCT_SCALE = 100;
  localparam logic [PCT_W-1:0] LIMIT_RESET = 7'd60;

  // Operation codes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

  // Slot marks.
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_USED = 2'd1;
  localparam logic [1:0] MARK_DEAD = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key;
    logic [HASH_W-1:0]   key_hash;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  live_count;
    logic [COUNT_W-1:0]  dead_count;
    logic [PCT_W-1:0]    load_percent;
    logic                over_limit;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic probe_step;
    logic sweep;
    logic finish;
  } lphs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_clear;
    logic mod_done;
    logic probe_end;
    logic sweep_last;
    logic out_free;
  } lphs_sts_t;

endpackage

// ===== hw/rtl/lphs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lphs_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_mod
// Reduces the 32-bit key hash modulo the table capacity.
// ----------------------------------------------------------------------------
module lphs_mod
  import lphs_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [HASH_W-1:0]           hash,
  output logic                        done,
  output logic [$clog2(CAPACITY)-1:0] rem
);

  localparam int AW = $clog2(CAPACITY);

  generate
    if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_pow2
      // A power-of-two capacity keeps only the low hash bits.
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem <= hash[AW-1:0];
        end
      end
    end else begin : g_iter
      // Restoring remainder, eight hash bits per cycle, most significant first.
      localparam int STEP_BITS = 8;
      localparam int NSTEP     = HASH_W / STEP_BITS;
      localparam int CNT_W     = $clog2(NSTEP);
      localparam int W         = AW + 1;

      logic              busy;
      logic [CNT_W-1:0]  cnt;
      logic [HASH_W-1:0] sh;
      logic [HASH_W-1:0] sh_next;
      logic [AW-1:0]     rem_next;

      always_comb begin
        logic [AW-1:0]     t;
        logic [HASH_W-1:0] s;
        logic [W-1:0]      w;
        t = rem;
        s = sh;
        for (int i = 0; i < STEP_BITS; i++) begin
          w = {t, s[HASH_W-1]};
          s = s << 1;
          if (w >= W'(CAPACITY)) begin
            w = w - W'(CAPACITY);
          end
          t = w[AW-1:0];
        end
        rem_next = t;
        sh_next  = s;
      end

      // Iteration control.
      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
          cnt  <= '0;
        end else if (start) begin
          busy <= 1'b1;
          done <= 1'b0;
          cnt  <= '0;
        end else if (busy) begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NSTEP - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          done <= 1'b0;
        end
      end

      // Remainder and shift register.
      always_ff @(posedge clk) begin
        if (start) begin
          rem <= '0;
          sh  <= hash;
        end else if (busy) begin
          rem <= rem_next;
          sh  <= sh_next;
        end
      end
    end
  endgenerate

endmodule

// ===== hw/rtl/lphs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_ctrl
// Sequencer for the hash set: initial sweep, hash reduction, probe walk,
// table clear and result hand-off.
// ----------------------------------------------------------------------------
module lphs_ctrl
  import lphs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  output lphs_cmd_t cmd,
  input  lphs_sts_t sts
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_HASH   = 6'b000100,
    S_PROBE  = 6'b001000,
    S_SWEEP  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the sweep that frees every slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = sts.req_clear ? S_SWEEP : S_HASH;
        end
      end
      S_HASH: begin
        if (sts.mod_done) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe_step = 1'b1;
        if (sts.probe_end) begin
          state_next = S_FINISH;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // Requests are taken only between operations.
  assign req_stall = (state != S_IDLE);

endmodule

// ===== hw/rtl/lphs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_dp
// Datapath of the hash set: slot memory, probe registers, counters,
// load percent tracking and the response register.
// ----------------------------------------------------------------------------
module lphs_dp
  import lphs_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [PCT_W-1:0] cfg_wdata,
  input  logic             rsp_stall,
  output logic             rsp_valid,
  output rsp_t             rsp,
  input  lphs_cmd_t        cmd,
  output lphs_sts_t        sts
);

  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int ACC_W    = AW + 1;
  localparam int ENT_W    = KEY_WIDTH + 2;
  localparam int PCT_STEP = PCT_SCALE / CAPACITY;
  localparam int PCT_REM  = PCT_SCALE % CAPACITY;

  // Request registers.
  logic [OPCODE_W-1:0]  op_r;
  logic [KEY_WIDTH-1:0] key_r;

  // Probe walk registers.
  logic [AW-1:0] probe_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_pend;
  logic [AW-1:0] seen;
  logic          hit;
  logic          has_dead;
  logic          has_free;
  logic [AW-1:0] dead_at;
  logic [AW-1:0] end_at;

  // Sweep, counters and configuration.
  logic [AW-1:0]    sweep_cnt;
  logic [CW-1:0]    used_cnt;
  logic [CW-1:0]    dead_cnt;
  logic [PCT_W-1:0] pct;
  logic [AW-1:0]    acc;
  logic [PCT_W-1:0] limit;

  // Memory and hash reduction.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic             mod_start;
  logic             mod_done;
  logic [AW-1:0]    mod_rem;

  // Finish-step results.
  logic                fin_we;
  logic [AW-1:0]       fin_addr;
  logic [1:0]          fin_mark;
  logic [STATUS_W-1:0] fin_status;
  logic [AW-1:0]       fin_slot;
  logic                fin_grow;
  logic                fin_clear;
  logic [CW-1:0]       used_next;
  logic [CW-1:0]       dead_next;
  logic [ACC_W-1:0]    acc_sum;
  logic                acc_carry;
  logic [ACC_W-1:0]    acc_inc;
  logic [PCT_W-1:0]    pct_next;
  logic [AW-1:0]       acc_next;

  // Slot examination.
  logic [1:0]           rd_mark;
  logic [KEY_WIDTH-1:0] rd_key;
  logic                 is_free;
  logic                 is_hit;
  logic                 is_dead;
  logic                 is_last;
  logic                 sweep_last;

  lphs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe_addr),
    .rdata (ram_rdata)
  );

  assign mod_start = cmd.capture && (req.opcode != OP_CLEAR);

  lphs_mod #(
    .CAPACITY (CAPACITY)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .hash  (req.key_hash),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Decode of the slot returned by the previous read.
  assign rd_mark = ram_rdata[ENT_W-1 -: 2];
  assign rd_key  = ram_rdata[KEY_WIDTH-1:0];
  assign is_free = (rd_mark == MARK_FREE);
  assign is_hit  = (rd_mark == MARK_USED) && (rd_key == key_r);
  assign is_dead = (rd_mark == MARK_DEAD);
  assign is_last = (seen == AW'(CAPACITY - 1));

  assign sweep_last = (sweep_cnt == AW'(CAPACITY - 1));

  // Status to the controller.
  assign sts.req_clear  = (req.opcode == OP_CLEAR);
  assign sts.mod_done   = mod_done;
  assign sts.probe_end  = rd_pend && (is_free || is_hit || is_last);
  assign sts.sweep_last = sweep_last;
  assign sts.out_free   = !rsp_valid || !rsp_stall;

  // Request capture and probe walk; one slot is read and one examined per cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= req.opcode;
      key_r    <= KEY_WIDTH'(req.key);
      seen     <= '0;
      hit      <= 1'b0;
      has_dead <= 1'b0;
      has_free <= 1'b0;
    end else if (cmd.probe_step && rd_pend) begin
      seen <= seen + 1'b1;
      if (is_dead && !has_dead) begin
        has_dead <= 1'b1;
        dead_at  <= rd_addr;
      end
      if (is_hit) begin
        hit <= 1'b1;
      end
      if (is_free) begin
        has_free <= 1'b1;
      end
      end_at <= rd_addr;
    end
    if (mod_done) begin
      probe_addr <= mod_rem;
    end else if (cmd.probe_step) begin
      probe_addr <= (probe_addr == AW'(CAPACITY - 1)) ? '0 : probe_addr + 1'b1;
      rd_addr    <= probe_addr;
    end
  end

  // Read-pending flag marks that the RAM output belongs to the walk.
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      rd_pend <= 1'b0;
    end else if (cmd.probe_step) begin
      rd_pend <= 1'b1;
    end
  end

  // Outcome of the operation once the walk or sweep is over.
  always_comb begin
    fin_we     = 1'b0;
    fin_addr   = end_at;
    fin_mark   = MARK_USED;
    fin_status = ST_NOT_FOUND;
    fin_slot   = '0;
    fin_grow   = 1'b0;
    fin_clear  = 1'b0;
    used_next  = used_cnt;
    dead_next  = dead_cnt;
    case (op_r)
      OP_LOOKUP: begin
        if (hit) begin
          fin_status = ST_FOUND;
          fin_slot   = end_at;
        end
      end
      OP_INSERT: begin
        if (hit) begin
          fin_we     = 1'b1;
          fin_status = ST_REPLACED;
          fin_slot   = end_at;
        end else if (has_dead) begin
          fin_we     = 1'b1;
          fin_addr   = dead_at;
          fin_status = ST_INSERTED;
          fin_slot   = dead_at;
          used_next  = used_cnt + 1'b1;
          dead_next  = dead_cnt - 1'b1;
        end else if (has_free) begin
          fin_we     = 1'b1;
          fin_status = ST_INSERTED;
          fin_slot   = end_at;
          fin_grow   = 1'b1;
          used_next  = used_cnt + 1'b1;
        end else begin
          fin_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          fin_we     = 1'b1;
          fin_mark   = MARK_DEAD;
          fin_status = ST_REMOVED;
          fin_slot   = end_at;
          used_next  = used_cnt - 1'b1;
          dead_next  = dead_cnt + 1'b1;
        end
      end
      OP_CLEAR: begin
        fin_status = ST_CLEARED;
        fin_clear  = 1'b1;
        used_next  = '0;
        dead_next  = '0;
      end
      default: begin
        fin_status = ST_NOT_FOUND;
      end
    endcase
  end

  // Load percent follows the occupied total, which only grows by one or clears.
  // The remainder of total * 100 / capacity is kept beside the quotient.
  assign acc_sum   = {1'b0, acc} + ACC_W'(PCT_REM);
  assign acc_carry = (acc_sum >= ACC_W'(CAPACITY));
  assign acc_inc   = acc_carry ? acc_sum - ACC_W'(CAPACITY) : acc_sum;

  always_comb begin
    pct_next = pct;
    acc_next = acc;
    if (fin_clear) begin
      pct_next = '0;
      acc_next = '0;
    end else if (fin_grow) begin
      pct_next = pct + PCT_W'(PCT_STEP) + PCT_W'(acc_carry);
      acc_next = acc_inc[AW-1:0];
    end
  end

  // Slot memory write: the sweep frees slots, the finish step updates one.
  always_comb begin
    if (cmd.sweep) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt;
      ram_wdata = {MARK_FREE, {KEY_WIDTH{1'b0}}};
    end else begin
      ram_we    = cmd.finish && fin_we;
      ram_waddr = fin_addr;
      ram_wdata = {fin_mark, key_r};
    end
  end

  // Sweep address counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_last ? '0 : sweep_cnt + 1'b1;
    end
  end

  // Occupancy counters and load tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_cnt <= '0;
      dead_cnt <= '0;
      pct      <= '0;
      acc      <= '0;
    end else if (cmd.finish) begin
      used_cnt <= used_next;
      dead_cnt <= dead_next;
      pct      <= pct_next;
      acc      <= acc_next;
    end
  end

  // Load limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // Response register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status       <= fin_status;
      rsp.slot_index   <= SLOT_W'(fin_slot);
      rsp.live_count   <= COUNT_W'(used_next);
      rsp.dead_count   <= COUNT_W'(dead_next);
      rsp.load_percent <= pct_next;
      rsp.over_limit   <= (pct_next >= limit);
    end
  end

endmodule

// ===== hw/rtl/linear_probe_hash_set_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core
// Fixed-capacity hash set with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Usage:
//   A request (opcode, key, key_hash) is taken on req when req_valid is high
//   and req_stall is low. One response (status, slot, counts, load percent,
//   over-limit flag) comes out on rsp for every request; it is taken when
//   rsp_valid is high and rsp_stall is low. cfg_we writes the load limit.
// Operation:
//   Lookup, insert and remove walk the slot memory one slot per cycle through
//   its single read port, after the hash has been reduced to a start slot;
//   a finish step then loads the response register, and the next request is
//   taken only after that. Capacities that are not a power of two reduce the
//   hash by an iterative restoring remainder instead of keeping its low bits.
//   Clear frees every slot in a sweep of the whole table, then finishes.
// Reset:
//   After rst the block sweeps all CAPACITY slots to free and holds req_stall
//   high until the sweep ends; the limit register returns to 60 percent.
// Stall:
//   A stalled response holds in the output register. The block takes the
//   next request meanwhile and waits only when that request's response is
//   ready and the register is still occupied.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_core
  import lphs_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [PCT_W-1:0] cfg_wdata
);

  lphs_cmd_t cmd;
  lphs_sts_t sts;

  lphs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lphs_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== hw/rtl/lphs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_checker
// Port-level checks of the hash set, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_set_core_defines.svh"

module lphs_checker
  import lphs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled response keeps its valid and its fields.
  `LPHS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // One request at a time: after a request is taken the input stalls.
  `LPHS_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request taken back to back")

  // A clear leaves an empty table.
  `LPHS_ASSERT_SAME(a_clear_empty, rsp_valid && (rsp.status == ST_CLEARED), (rsp.live_count == '0) && (rsp.dead_count == '0) && (rsp.load_percent == '0), "clear left a nonzero count")

  // Responses without a slot report slot zero.
  `LPHS_ASSERT_SAME(a_no_slot_zero, rsp_valid && ((rsp.status == ST_NOT_FOUND) || (rsp.status == ST_FULL) || (rsp.status == ST_CLEARED)), rsp.slot_index == '0, "slot index set without a slot")

endmodule

bind linear_probe_hash_set_core lphs_checker u_checker (.*);

// ===== tb/lphs_hash_set_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_hash_set_checker
// Watches the request, response and limit-write ports of the hash set. It
// keeps a shadow copy of the slot table, predicts one response per accepted
// request and compares each accepted response, field by field, with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lphs_hash_set_checker
  import lphs_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [PCT_W-1:0] cfg_wdata,
  output int               error_count,
  output int               outstanding
);

  // Shadow copy of the table, its counters and the load limit.
  logic [1:0]       shadow_mark [CAPACITY];
  logic [KEY_W-1:0] shadow_key  [CAPACITY];
  int               shadow_live;
  int               shadow_dead;
  logic [PCT_W-1:0] shadow_limit;

  // Responses predicted but not yet seen, oldest first.
  rsp_t             pending_rsp [$];
  rsp_t             oldest_rsp;
  int               mismatches = 0;
  int               pending_now = 0;

  assign error_count = mismatches;
  assign outstanding = pending_now;

  // Applies one request to the shadow table and returns the response it
  // should produce.
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int   pos;
    int   hit_at;
    int   dead_at;
    int   free_at;
    int   load;
    res     = '0;
    hit_at  = -1;
    dead_at = -1;
    free_at = -1;

    // Linear probe: stop at a free slot, at the key, or after one full wrap.
    // The first tombstone passed on the way is remembered for inserts.
    if (op_t'(r.opcode) != OP_CLEAR) begin
      pos = r.key_hash % CAPACITY;
      for (int n = 0; n < CAPACITY && hit_at < 0 && free_at < 0; n++) begin
        if (shadow_mark[pos] == MARK_FREE) begin
          free_at = pos;
        end else if (shadow_mark[pos] == MARK_USED && shadow_key[pos] == r.key) begin
          hit_at = pos;
        end else begin
          if (shadow_mark[pos] == MARK_DEAD && dead_at < 0) begin
            dead_at = pos;
          end
          pos = (pos + 1) % CAPACITY;
        end
      end
    end

    case (op_t'(r.opcode))
      OP_LOOKUP: begin
        if (hit_at >= 0) begin
          res.status     = ST_FOUND;
          res.slot_index = SLOT_W'(hit_at);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_INSERT: begin
        if (hit_at >= 0) begin
          // Key already present: overwrite in place, counts unchanged.
          shadow_key[hit_at] = r.key;
          res.status         = ST_REPLACED;
          res.slot_index     = SLOT_W'(hit_at);
        end else if (dead_at >= 0) begin
          // Reuse the first tombstone seen on the walk.
          shadow_mark[dead_at] = MARK_USED;
          shadow_key[dead_at]  = r.key;
          shadow_live++;
          shadow_dead--;
          res.status     = ST_INSERTED;
          res.slot_index = SLOT_W'(dead_at);
        end else if (free_at >= 0) begin
          shadow_mark[free_at] = MARK_USED;
          shadow_key[free_at]  = r.key;
          shadow_live++;
          res.status     = ST_INSERTED;
          res.slot_index = SLOT_W'(free_at);
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit_at >= 0) begin
          shadow_mark[hit_at] = MARK_DEAD;
          shadow_live--;
          shadow_dead++;
          res.status     = ST_REMOVED;
          res.slot_index = SLOT_W'(hit_at);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        foreach (shadow_mark[i]) shadow_mark[i] = MARK_FREE;
        shadow_live = 0;
        shadow_dead = 0;
        res.status  = ST_CLEARED;
      end
    endcase

    load             = (shadow_live + shadow_dead) * PCT_SCALE / CAPACITY;
    res.live_count   = COUNT_W'(shadow_live);
    res.dead_count   = COUNT_W'(shadow_dead);
    res.load_percent = PCT_W'(load);
    res.over_limit   = (load >= shadow_limit);
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(string field, logic [31:0] expected_value,
                             logic [31:0] actual_value);
    if (actual_value !== expected_value) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d",
               $time, field, expected_value, actual_value);
    end
  endtask

  // Responses are matched before new requests are queued, so a response
  // always belongs to a request taken at an earlier edge.
  always @(posedge clk) begin
    if (rst) begin
      foreach (shadow_mark[i]) shadow_mark[i] = MARK_FREE;
      shadow_live  = 0;
      shadow_dead  = 0;
      shadow_limit = LIMIT_RESET;
      pending_rsp.delete();
    end else begin
      if (cfg_we) begin
        shadow_limit = cfg_wdata;
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: response with no request waiting: expected none, got status %0d",
                   $time, rsp.status);
        end else begin
          oldest_rsp = pending_rsp.pop_front();
          check_field("status", 32'(oldest_rsp.status), 32'(rsp.status));
          check_field("slot_index", 32'(oldest_rsp.slot_index), 32'(rsp.slot_index));
          check_field("live_count", 32'(oldest_rsp.live_count), 32'(rsp.live_count));
          check_field("dead_count", 32'(oldest_rsp.dead_count), 32'(rsp.dead_count));
          check_field("load_percent", 32'(oldest_rsp.load_percent),
                      32'(rsp.load_percent));
          check_field("over_limit", 32'(oldest_rsp.over_limit), 32'(rsp.over_limit));
        end
      end
      if (req_valid && !req_stall) begin
        pending_rsp.push_back(apply_request(req));
      end
    end
    pending_now <= pending_rsp.size();
  end

endmodule

// ===== tb/tb_linear_probe_hash_set_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_set_core
// Drives the linear probing hash set with a short directed sequence (wrap at
// the table end, replace, tombstone reuse, missing remove, clear), then
// random mixes over small colliding key pools and a full-table phase that
// exercises full-wrap probes. The sender pauses between bursts and the
// receiver stalls on its own pattern; a checker predicts every response.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_set_core;
  import lphs_pkg::*;

  localparam int CAPACITY       = DEF_CAPACITY;
  localparam int POOL_SIZE      = 48;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 16;

  logic             clk;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             cfg_we    = 1'b0;
  logic [PCT_W-1:0] cfg_wdata = '0;

  int               errors;
  int               outstanding;
  int               burst_left   = 0;
  int               quiet_cycles = 0;
  int               stall_mode   = 0;
  int               mode_left    = 0;

  // Key pool for the random mixes and the keys used to fill the table.
  logic [KEY_W-1:0]  pool_key  [POOL_SIZE];
  logic [HASH_W-1:0] pool_hash [POOL_SIZE];
  logic [KEY_W-1:0]  fill_key  [CAPACITY];
  logic [HASH_W-1:0] fill_hash [CAPACITY];

  linear_probe_hash_set_core #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (DEF_KEY_WIDTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lphs_hash_set_checker #(
    .CAPACITY (CAPACITY)
  ) hash_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .error_count (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stall pattern: stretches of no stall, of scattered stalls and
  // of long stall runs.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(40, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       rsp_stall <= 1'b0;
      1:       rsp_stall <= ($urandom_range(0, 2) == 0);
      default: rsp_stall <= ($urandom_range(0, 15) == 0) ? ~rsp_stall : rsp_stall;
    endcase
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no request or response moved for %0d cycles",
               $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request and returns at the edge that takes it. Valid stays
  // high so the next request can follow back to back; a gap is inserted
  // only at the start of a new burst.
  task automatic send_req(input op_t op, input logic [KEY_W-1:0] item_key,
                          input logic [HASH_W-1:0] item_hash);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= '{opcode: op, key: item_key, key_hash: item_hash};
    do @(posedge clk); while (!(req_valid && !req_stall));
  endtask

  // Waits until every response has been taken, then writes the load limit.
  task automatic set_load_limit(input logic [PCT_W-1:0] value);
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Builds a key pool whose probe starts fall in a window of twelve slots,
  // so keys collide and chains, tombstones and wraps appear.
  task automatic build_pool(input int base_slot);
    logic [HASH_W-1:0] h;
    for (int i = 0; i < POOL_SIZE; i++) begin
      h               = $urandom();
      h[SLOT_W-1:0]   = SLOT_W'((base_slot + $urandom_range(0, 11)) % CAPACITY);
      pool_key[i]     = $urandom();
      pool_hash[i]    = h;
    end
  endtask

  // Mostly well-formed traffic on the pool, with some fully random requests
  // and an occasional clear.
  task automatic random_mix(input int count);
    int pick;
    int idx;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 40) begin
        send_req(OP_INSERT, pool_key[idx], pool_hash[idx]);
      end else if (pick < 65) begin
        send_req(OP_LOOKUP, pool_key[idx], pool_hash[idx]);
      end else if (pick < 88) begin
        send_req(OP_REMOVE, pool_key[idx], pool_hash[idx]);
      end else if (pick < 98) begin
        send_req(op_t'($urandom_range(0, 2)), $urandom(), $urandom());
      end else begin
        send_req(OP_CLEAR, $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    int victim;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the limit at zero, so the flag is always raised.
    set_load_limit(7'd0);
    send_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Starts at the last slot and wraps past slot zero.
    send_req(OP_INSERT, 32'h0000_0005, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_LOOKUP, 32'h0000_0005, 32'hFFFF_FFFF);
    send_req(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // The walk passes the new tombstone and still finds the key.
    send_req(OP_LOOKUP, 32'h0000_0005, 32'h0000_03FF);
    send_req(OP_REMOVE, 32'h0000_04D2, 32'h0000_03FF);
    // A new key reuses the tombstone at the end of the table.
    send_req(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_57FF);
    send_req(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    // A tombstone before a present key: the key is replaced, not duplicated.
    send_req(OP_INSERT, 32'h0000_0005, 32'h0000_0000);
    send_req(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_req(OP_REMOVE, 32'h5555_5555, 32'hAAAA_AAAA);
    send_req(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_LOOKUP, 32'h0000_0005, 32'h0000_0000);
    send_req(OP_INSERT, 32'h8000_0001, 32'h8000_0400);

    // Random mixes: limit above the load range, then a random limit with
    // the pool window straddling the end of the table.
    set_load_limit(7'd127);
    build_pool($urandom_range(0, CAPACITY - 1));
    random_mix(130);
    set_load_limit(PCT_W'($urandom_range(1, 99)));
    build_pool(CAPACITY - 8);
    random_mix(130);

    // Fill every slot, then probe the full table.
    set_load_limit(7'd100);
    send_req(OP_CLEAR, $urandom(), $urandom());
    for (int s = 0; s < CAPACITY; s++) begin
      fill_key[s]  = $urandom();
      fill_hash[s] = $urandom();
      send_req(OP_INSERT, fill_key[s], fill_hash[s]);
    end
    for (int j = 0; j < 3; j++) send_req(OP_LOOKUP, $urandom(), $urandom());
    for (int j = 0; j < 3; j++) send_req(OP_INSERT, $urandom(), $urandom());
    for (int j = 0; j < 10; j++) begin
      victim = $urandom_range(0, CAPACITY - 1);
      send_req(OP_LOOKUP, fill_key[victim], fill_hash[victim]);
    end
    for (int j = 0; j < 3; j++) begin
      victim = $urandom_range(0, CAPACITY - 1);
      send_req(OP_INSERT, fill_key[victim], fill_hash[victim]);
    end
    for (int j = 0; j < 2; j++) send_req(OP_REMOVE, $urandom(), $urandom());
    // Tombstones in a table with no free slot: later inserts wrap fully and
    // land in the first tombstone seen, then report a full table again.
    for (int j = 0; j < 8; j++) begin
      victim = (j * 97 + 5) % CAPACITY;
      send_req(OP_REMOVE, fill_key[victim], fill_hash[victim]);
    end
    send_req(OP_LOOKUP, fill_key[5], fill_hash[5]);
    for (int j = 0; j < 10; j++) send_req(OP_INSERT, $urandom(), $urandom());
    send_req(OP_CLEAR, $urandom(), $urandom());

    // Drain and give the verdict.
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
